// File: rtl/min_tracking_stack_assert.svh
// Assertion macros shared by the stack checker
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MTS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("min_tracking_stack assertion failed");

// consequent checked in the cycle after the antecedent
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("min_tracking_stack assertion failed");

`endif

// File: rtl/mts_pkg.sv
// Types and constants for the min-tracking stack
package mts_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - 2 * VALUE_W - 1 - STATUS_W;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

endpackage

// File: rtl/min_tracking_stack.sv
// Min-tracking stack: LIFO of signed 32-bit values that reports its minimum.
//
// Input channel (s): one word per operation. tuser selects push (0) or pop (1);
// tdata carries the value to push and is ignored on pop.
// Output channel (m): exactly one word per operation with the new top, the
// current minimum (both 0 when empty), an empty flag and a status code
// (ok, push refused because full, pop refused because empty).
// Timing: a push, a refused push and a refused pop load the output register at
// the accepting edge; a pop that removes a value first passes through S_LOAD,
// since the next top and next minimum are read back from the value and minimum
// RAMs, which have a registered read.
// The input is accepted again once the block is back in S_IDLE and the output
// register is free or is being taken in the same cycle; a stalled receiver
// holds the word, and no new input is taken until it is taken.
// Reset (synchronous, active low) empties both stacks; no clearing pass is
// needed because only entries below the counts are ever read.
module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int unsigned DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // [31:0] push_value
    input  logic                  i_s_tuser,  // [0] req_type
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata   // [31:0] top_value, [63:32] min_value,
                                              // [64] is_empty, [66:65] status, rest 0
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic              val_we;
    logic [AW-1:0]     val_waddr;
    logic [VALUE_W-1:0] val_wdata;
    logic [AW-1:0]     val_raddr;
    logic [VALUE_W-1:0] val_rdata;
    logic              min_we;
    logic [AW-1:0]     min_waddr;
    logic [VALUE_W-1:0] min_wdata;
    logic [AW-1:0]     min_raddr;
    logic [VALUE_W-1:0] min_rdata;

    mts_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_val_we    (val_we),
        .o_val_waddr (val_waddr),
        .o_val_wdata (val_wdata),
        .o_val_raddr (val_raddr),
        .i_val_rdata (val_rdata),
        .o_min_we    (min_we),
        .o_min_waddr (min_waddr),
        .o_min_wdata (min_wdata),
        .o_min_raddr (min_raddr),
        .i_min_rdata (min_rdata)
    );

    mts_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    mts_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (min_we),
        .i_waddr (min_waddr),
        .i_wdata (min_wdata),
        .i_raddr (min_raddr),
        .o_rdata (min_rdata)
    );

endmodule

// File: rtl/mts_ram.sv
// Generic simple dual-port RAM with registered read
module mts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mts_ctrl.sv
// Stack control: counters, cached tops, RAM access sequencing and output word register
module mts_ctrl
    import mts_pkg::*;
#(
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [IN_DATA_W-1:0]     i_s_tdata,
    input  logic                     i_s_tuser,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_DATA_W-1:0]    o_m_tdata,
    output logic                     o_val_we,
    output logic [$clog2(DEPTH)-1:0] o_val_waddr,
    output logic [VALUE_W-1:0]       o_val_wdata,
    output logic [$clog2(DEPTH)-1:0] o_val_raddr,
    input  logic [VALUE_W-1:0]       i_val_rdata,
    output logic                     o_min_we,
    output logic [$clog2(DEPTH)-1:0] o_min_waddr,
    output logic [VALUE_W-1:0]       o_min_wdata,
    output logic [$clog2(DEPTH)-1:0] o_min_raddr,
    input  logic [VALUE_W-1:0]       i_min_rdata
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state               r_state, n_state;
    logic [CW-1:0]        r_vcnt, n_vcnt;
    logic [CW-1:0]        r_mcnt, n_mcnt;
    logic [VALUE_W-1:0]   r_top, n_top;
    logic [VALUE_W-1:0]   r_min, n_min;
    logic                 r_min_pop, n_min_pop;
    logic                 r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]   r_out_top, n_out_top;
    logic [VALUE_W-1:0]   r_out_min, n_out_min;
    logic                 r_out_empty, n_out_empty;
    t_status              r_out_status, n_out_status;

    logic                 accept;
    logic                 out_load;
    t_req                 req;
    logic [VALUE_W-1:0]   push_val;
    logic [CW-1:0]        vcnt_m2;
    logic [CW-1:0]        mcnt_m2;
    logic                 min_push;

    assign req      = t_req'(i_s_tuser);
    assign push_val = i_s_tdata[VALUE_W-1:0];
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept   = i_s_tvalid && o_s_tready;
    assign vcnt_m2  = r_vcnt - CW'(2);
    assign mcnt_m2  = r_mcnt - CW'(2);
    assign min_push = (r_mcnt == '0) || ($signed(push_val) <= $signed(r_min));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && req == REQ_POP && r_vcnt != '0) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_vcnt       = r_vcnt;
        n_mcnt       = r_mcnt;
        n_top        = r_top;
        n_min        = r_min;
        n_min_pop    = r_min_pop;
        out_load     = 1'b0;
        n_out_top    = r_out_top;
        n_out_min    = r_out_min;
        n_out_empty  = r_out_empty;
        n_out_status = r_out_status;
        o_val_we     = 1'b0;
        o_val_waddr  = r_vcnt[AW-1:0];
        o_val_wdata  = push_val;
        o_val_raddr  = vcnt_m2[AW-1:0];
        o_min_we     = 1'b0;
        o_min_waddr  = r_mcnt[AW-1:0];
        o_min_wdata  = push_val;
        o_min_raddr  = mcnt_m2[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (req == REQ_PUSH) begin
                        if (r_vcnt == FULL_CNT) begin
                            out_load     = 1'b1;
                            n_out_top    = r_top;
                            n_out_min    = r_min;
                            n_out_empty  = 1'b0;
                            n_out_status = ST_FULL;
                        end else begin
                            o_val_we = 1'b1;
                            n_vcnt   = r_vcnt + CW'(1);
                            n_top    = push_val;
                            if (min_push) begin
                                o_min_we = 1'b1;
                                n_mcnt   = r_mcnt + CW'(1);
                                n_min    = push_val;
                            end
                            out_load     = 1'b1;
                            n_out_top    = push_val;
                            n_out_min    = min_push ? push_val : r_min;
                            n_out_empty  = 1'b0;
                            n_out_status = ST_OK;
                        end
                    end else begin
                        if (r_vcnt == '0) begin
                            out_load     = 1'b1;
                            n_out_top    = '0;
                            n_out_min    = '0;
                            n_out_empty  = 1'b1;
                            n_out_status = ST_EMPTY;
                        end else begin
                            // new tops come back from the RAMs next cycle
                            n_vcnt    = r_vcnt - CW'(1);
                            n_min_pop = (r_top == r_min);
                            if (r_top == r_min) begin
                                n_mcnt = r_mcnt - CW'(1);
                            end
                        end
                    end
                end
            end
            S_LOAD: begin
                n_top = i_val_rdata;
                if (r_min_pop) begin
                    n_min = i_min_rdata;
                end
                out_load     = 1'b1;
                n_out_empty  = (r_vcnt == '0);
                n_out_top    = (r_vcnt == '0) ? '0 : i_val_rdata;
                n_out_min    = (r_vcnt == '0) ? '0 : (r_min_pop ? i_min_rdata : r_min);
                n_out_status = ST_OK;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcnt      <= '0;
            r_mcnt      <= '0;
            r_min_pop   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcnt      <= n_vcnt;
            r_mcnt      <= n_mcnt;
            r_min_pop   <= n_min_pop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_min        <= n_min;
        r_out_top    <= n_out_top;
        r_out_min    <= n_out_min;
        r_out_empty  <= n_out_empty;
        r_out_status <= n_out_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_status, r_out_empty, r_out_min, r_out_top};

endmodule

// File: rtl/mts_checker.sv
// Port-level checker for the min-tracking stack, bound to the top level
`include "min_tracking_stack_assert.svh"

module mts_checker
    import mts_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  i_s_tready,
    input logic                  i_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] i_m_tdata
);

    logic [VALUE_W-1:0]  top;
    logic [VALUE_W-1:0]  min;
    logic                empty;
    logic [STATUS_W-1:0] status;
    logic                s_seen;

    assign top    = i_m_tdata[31:0];
    assign min    = i_m_tdata[63:32];
    assign empty  = i_m_tdata[64];
    assign status = i_m_tdata[66:65];
    assign s_seen = i_s_tvalid && i_s_tready;

    `MTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)
    `MTS_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, i_m_tvalid && empty, top == '0 && min == '0)
    `MTS_ASSERT_SAME(a_status_flag, i_clk, i_rst_n, i_m_tvalid && status == ST_EMPTY, empty)
    `MTS_ASSERT_SAME(a_full_nonempty, i_clk, i_rst_n, i_m_tvalid && status == ST_FULL, !empty)
    `MTS_ASSERT_SAME(a_min_le_top, i_clk, i_rst_n, i_m_tvalid && !empty && !s_seen, $signed(min) <= $signed(top))

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
